// ----- rtl/core/lut3d_pkg.sv -----
// ----------------------------------------------------------------------------
// lut3d_pkg
// Shared types and constants of the 3D LUT trilinear color mapper.
// ----------------------------------------------------------------------------
`default_nettype none
package lut3d_pkg;

  localparam int unsigned AddrW  = 18;
  localparam int unsigned CoordW = 6;
  localparam int unsigned ChW    = 8;
  localparam int unsigned SizeW  = 7;
  localparam int unsigned EntryW = 24;

  localparam logic [7:0]  WeightOne  = 8'd255;
  localparam logic [23:0] Denom      = 24'd16581375;  // 255^3
  localparam logic [31:0] RoundHalf  = 32'd8290687;   // (255^3-1)/2
  localparam logic [8:0]  RecipDenom = 9'd259;        // ~2^32/255^3, rounded down

  typedef enum logic {
    CmdWrite = 1'b0,
    CmdPixel = 1'b1
  } cmd_e;

  // base[{b,g}] = N*(g + N*b); ridx[0/1] = red lo/hi; fw: blue, green, red
  typedef struct packed {
    cmd_e                         cmd;
    logic [AddrW-1:0]             waddr;
    logic [EntryW-1:0]            wdata;
    logic [3:0][AddrW-1:0]        base;
    logic [1:0][CoordW-1:0]       ridx;
    logic [2:0][ChW-1:0]          fw;
  } qitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

// ----- rtl/core/lut3d_ram.sv -----
// ----------------------------------------------------------------------------
// lut3d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lut3d_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 262144
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lut3d_front.sv -----
// ----------------------------------------------------------------------------
// lut3d_front
// Scales pixel channels, splits them into lattice index and weight, and
// forms the corner base addresses; write items pass through.
// ----------------------------------------------------------------------------
`default_nettype none
module lut3d_front
  import lut3d_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [SizeW-1:0] n_i,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire cmd_e             cmd_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [ChW-1:0]   blue_i,
  input  wire logic [ChW-1:0]   green_i,
  input  wire logic [ChW-1:0]   red_i,
  output logic                  q_valid_o,
  output qitem_t                q_item_o,
  input  wire qstat_t           q_stat_i
);

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  cmd_e                    cmd1_q, cmd2_q, cmd3_q;
  logic [AddrW-1:0]        addr1_q, addr2_q, addr3_q;
  logic [EntryW-1:0]       data1_q, data2_q, data3_q;
  logic [2:0][14:0]        p1_q;
  logic [2:0][CoordW-1:0]  lo2_q, hi2_q;
  logic [2:0][ChW-1:0]     fw2_q, fw3_q;
  logic [1:0][CoordW-1:0]  g3_q, r3_q;
  logic [1:0][12:0]        nb3_q;
  qitem_t                  item4_q;

  logic [SizeW-1:0]        nm1;
  logic [2:0][ChW-1:0]     ch;
  logic [2:0][14:0]        p_d;
  logic [2:0][CoordW-1:0]  lo_d, hi_d;
  logic [2:0][ChW-1:0]     fw_d;
  logic [1:0][12:0]        nb_d;
  logic [3:0][AddrW-1:0]   base_d;

  assign en        = !v4_q || !q_stat_i.full;
  assign ready_o   = en;
  assign q_valid_o = v4_q;
  assign q_item_o  = item4_q;

  always_comb begin
    logic [23:0]      t;
    logic [ChW-1:0]   q;
    logic [14:0]      rem;
    logic [SizeW-1:0] lo1;
    logic [19:0]      gsum;
    nm1   = n_i - 7'd1;
    ch[0] = blue_i;
    ch[1] = green_i;
    ch[2] = red_i;
    for (int k = 0; k < 3; k++) begin
      p_d[k] = 15'(ch[k]) * 15'(nm1);
      t      = 24'(p1_q[k]) * 24'd257;
      q      = t[23:16];
      rem    = p1_q[k] - 15'(q) * 15'(WeightOne);
      if (rem >= 15'(WeightOne)) begin
        lo_d[k] = CoordW'(q + 8'd1);
        fw_d[k] = 8'(rem - 15'(WeightOne));
      end else begin
        lo_d[k] = CoordW'(q);
        fw_d[k] = 8'(rem);
      end
      lo1 = 7'(lo_d[k]) + 7'd1;
      hi_d[k] = (lo1 < n_i) ? CoordW'(lo1) : CoordW'(nm1);
    end
    nb_d[0] = 13'(n_i) * 13'(lo2_q[0]);
    nb_d[1] = 13'(n_i) * 13'(hi2_q[0]);
    for (int c = 0; c < 4; c++) begin
      gsum      = 20'(g3_q[c % 2]) + 20'(nb3_q[c / 2]);
      base_d[c] = AddrW'(20'(n_i) * gsum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q  <= cmd_i;
      addr1_q <= addr_i;
      data1_q <= {red_i, green_i, blue_i};
      p1_q    <= p_d;

      cmd2_q  <= cmd1_q;
      addr2_q <= addr1_q;
      data2_q <= data1_q;
      lo2_q   <= lo_d;
      hi2_q   <= hi_d;
      fw2_q   <= fw_d;

      cmd3_q  <= cmd2_q;
      addr3_q <= addr2_q;
      data3_q <= data2_q;
      nb3_q   <= nb_d;
      g3_q    <= {hi2_q[1], lo2_q[1]};
      r3_q    <= {hi2_q[2], lo2_q[2]};
      fw3_q   <= fw2_q;

      item4_q.cmd   <= cmd3_q;
      item4_q.waddr <= addr3_q;
      item4_q.wdata <= data3_q;
      item4_q.base  <= base_d;
      item4_q.ridx  <= r3_q;
      item4_q.fw    <= fw3_q;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lut3d_fifo.sv -----
// ----------------------------------------------------------------------------
// lut3d_fifo
// Four-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module lut3d_fifo
  import lut3d_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_valid_i,
  input  wire qitem_t push_item_i,
  input  wire logic   pop_i,
  output qitem_t      pop_item_o,
  output qstat_t      stat_o
);

  qitem_t     mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;
  logic       push;

  assign stat_o.full  = (cnt_q == 3'd4);
  assign stat_o.empty = (cnt_q == 3'd0);
  assign push         = push_valid_i && !stat_o.full;
  assign pop_item_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 2'd1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 2'd1;
      end
      cnt_q <= cnt_q + 3'(push) - 3'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lut3d_back.sv -----
// ----------------------------------------------------------------------------
// lut3d_back
// Table writes, eight-corner reads from replicated RAMs, weight products,
// blend and rounding into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module lut3d_back
  import lut3d_pkg::*;
#(
  parameter int unsigned MAX_LUT_SIZE = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire qitem_t          q_item_i,
  input  wire qstat_t          q_stat_i,
  output logic                 pop_o,
  output logic                 m_valid_o,
  input  wire logic            m_ready_i,
  output logic [2:0][ChW-1:0]  m_data_o
);

  localparam int unsigned Depth = MAX_LUT_SIZE * MAX_LUT_SIZE * MAX_LUT_SIZE;
  localparam int unsigned RamAw = $clog2(Depth);

  logic ok, we, re;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, mv_q;

  logic [7:0][RamAw-1:0]    raddr;
  logic [7:0][EntryW-1:0]   rdata;
  logic [2:0][ChW-1:0]      fw1_q;
  logic [3:0][15:0]         wrg_d, wrg2_q;
  logic [1:0][ChW-1:0]      wb2_q;
  logic [7:0][EntryW-1:0]   e2_q, e3_q;
  logic [7:0][23:0]         w_d, w3_q;
  logic [2:0][7:0][31:0]    prod_d, prod4_q;
  logic [2:0][3:0][31:0]    s_d, s5_q;
  logic [2:0][31:0]         x_d, x6_q, x7_q;
  logic [2:0][8:0]          q_d, q7_q;
  logic [2:0][ChW-1:0]      v_d, out_q;

  assign ok        = !mv_q || m_ready_i;
  assign pop_o     = ok && !q_stat_i.empty;
  assign we        = pop_o && (q_item_i.cmd == CmdWrite) &&
                     (19'(q_item_i.waddr) < 19'(Depth));
  assign re        = pop_o && (q_item_i.cmd == CmdPixel);
  assign m_valid_o = mv_q;
  assign m_data_o  = out_q;

  always_comb begin
    logic [AddrW-1:0] a;
    for (int c = 0; c < 8; c++) begin
      a        = q_item_i.base[c / 2] + AddrW'(q_item_i.ridx[c % 2]);
      raddr[c] = a[RamAw-1:0];
    end
  end

  for (genvar c = 0; c < 8; c++) begin : g_bank
    lut3d_ram #(
      .Width (EntryW),
      .Depth (Depth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (q_item_i.waddr[RamAw-1:0]),
      .wdata_i (q_item_i.wdata),
      .re_i    (re && ok),
      .raddr_i (raddr[c]),
      .rdata_o (rdata[c])
    );
  end

  always_comb begin
    logic [ChW-1:0] wr, wg;
    logic [32:0]    rem;
    logic [40:0]    t;
    logic [8:0]     v;
    for (int c = 0; c < 4; c++) begin
      wr       = (c % 2 == 1) ? fw1_q[2] : WeightOne - fw1_q[2];
      wg       = (c / 2 == 1) ? fw1_q[1] : WeightOne - fw1_q[1];
      wrg_d[c] = 16'(wr) * 16'(wg);
    end
    for (int c = 0; c < 8; c++) begin
      w_d[c] = 24'(wrg2_q[c % 4]) * 24'(wb2_q[c / 4]);
    end
    for (int k = 0; k < 3; k++) begin
      for (int c = 0; c < 8; c++) begin
        prod_d[k][c] = 32'(e3_q[c][k*8 +: 8]) * 32'(w3_q[c]);
      end
      for (int j = 0; j < 4; j++) begin
        s_d[k][j] = prod4_q[k][2*j] + prod4_q[k][2*j+1];
      end
      x_d[k] = s5_q[k][0] + s5_q[k][1] + s5_q[k][2] + s5_q[k][3] + RoundHalf;
      t      = 41'(x6_q[k]) * 41'(RecipDenom);
      q_d[k] = t[40:32];
      rem    = 33'(x7_q[k]) - 33'(q7_q[k]) * 33'(Denom);
      v      = (rem >= 33'(Denom)) ? q7_q[k] + 9'd1 : q7_q[k];
      v_d[k] = v[ChW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      mv_q <= 1'b0;
    end else if (ok) begin
      v1_q <= re;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      mv_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ok) begin
      fw1_q   <= q_item_i.fw;
      wrg2_q  <= wrg_d;
      wb2_q   <= {fw1_q[0], WeightOne - fw1_q[0]};
      e2_q    <= rdata;
      w3_q    <= w_d;
      e3_q    <= e2_q;
      prod4_q <= prod_d;
      s5_q    <= s_d;
      x6_q    <= x_d;
      x7_q    <= x6_q;
      q7_q    <= q_d;
      out_q   <= v_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lut3d_trilinear_color_map.sv -----
// ----------------------------------------------------------------------------
// lut3d_trilinear_color_map
// 3D LUT color grading with trilinear blend of the eight lattice corners.
//
//   channel  dir  fields
//   s_axis   in   tuser: command; tdata: entry_index, blue, green, red
//   m_axis   out  tdata: out_blue, out_green, out_red
//   cfg      in   lut_size (write only)
//
// One item per clock sustained while the output is not stalled. Eight
// replicated table RAMs give the eight corner reads in the same cycle. Table
// contents are undefined after reset; no clearing pass. A stalled output
// freezes the back part; the four-entry queue lets the front part keep taking
// items until it fills.
// ----------------------------------------------------------------------------
`default_nettype none
module lut3d_trilinear_color_map
  import lut3d_pkg::*;
#(
  parameter int unsigned MAX_LUT_SIZE = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [SizeW-1:0] cfg_wdata_i,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [47:0]      s_axis_tdata_i,   // entry_index, blue, green, red
  input  wire logic             s_axis_tuser_i,   // command
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic [23:0]           m_axis_tdata_o    // out_blue, out_green, out_red
);

  logic [SizeW-1:0]     lut_size_q, n_eff;
  logic                 f_valid, b_pop;
  qitem_t               f_item, q_item;
  qstat_t               q_stat;
  logic [2:0][ChW-1:0]  m_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lut_size_q <= 7'd64;
    end else if (cfg_we_i) begin
      lut_size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (lut_size_q < 7'd2) begin
      n_eff = 7'd2;
    end else if (lut_size_q > SizeW'(MAX_LUT_SIZE)) begin
      n_eff = SizeW'(MAX_LUT_SIZE);
    end else begin
      n_eff = lut_size_q;
    end
  end

  lut3d_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .n_i       (n_eff),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .cmd_i     (cmd_e'(s_axis_tuser_i)),
    .addr_i    (s_axis_tdata_i[17:0]),
    .blue_i    (s_axis_tdata_i[25:18]),
    .green_i   (s_axis_tdata_i[33:26]),
    .red_i     (s_axis_tdata_i[41:34]),
    .q_valid_o (f_valid),
    .q_item_o  (f_item),
    .q_stat_i  (q_stat)
  );

  lut3d_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_item_i  (f_item),
    .pop_i        (b_pop),
    .pop_item_o   (q_item),
    .stat_o       (q_stat)
  );

  lut3d_back #(
    .MAX_LUT_SIZE (MAX_LUT_SIZE)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_item_i  (q_item),
    .q_stat_i  (q_stat),
    .pop_o     (b_pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_data)
  );

  assign m_axis_tdata_o = {m_data[2], m_data[1], m_data[0]};

`ifndef NO_ASSERTIONS
  a_stat_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !b_pop)
    else $error("queue popped while output stalled");

  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_eff >= 7'd2) && (n_eff <= SizeW'(MAX_LUT_SIZE)))
    else $error("effective lut size out of range");
`endif

endmodule
`default_nettype wire
